// ===== rtl/swstat_pkg.sv =====
package swstat_pkg;

	localparam int DEPTH       = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int PTR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_BITS  = $clog2(DEPTH + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
	localparam int LENGTH_BITS = 7;
	localparam int LENGTH_RESET = 64;
	localparam int DIVC_BITS   = $clog2(SUM_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic div_start;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/sliding_window_statistics.sv =====
// Sliding-window statistics over a stream of signed samples.
// Input channel: sample with sample_valid; the block drives sample_stall.
// A transaction completes on a rising edge with valid high and stall low.
// Output channel: window_count/min/max/sum/mean with result_valid; the
// receiver drives result_stall. One result transaction per input sample.
// From input transaction to result_valid, the sample goes through the scan
// of the ring memory (one read port, one entry a cycle, a read pipeline
// register), the start of the divider, SUM_BITS (22) steps of the serial
// divider for the mean, the exit from the divider and the load of the
// output register.
// One sample is worked on at a time: the controller goes back to idle
// before it takes the next, so a new sample is taken only after the last
// result has been loaded into the output register.
// The output register parts the two sides: a finished result waits there
// while the next sample is already taken and scanned; only the load of a
// new result waits for the receiver to lift result_stall, and sample_stall
// stays high until that load.
// window_length may be written while the block is idle; 0 acts as 1 and
// values above the depth act as the depth. Reset empties the window, sets
// the length to 64 and drops any pending result. The sample memory itself
// is not cleared; only written entries are ever read.
module sliding_window_statistics
	import swstat_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          window_length_write,
	input  logic [LENGTH_BITS-1:0]        window_length,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [COUNT_BITS-1:0]         window_count,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SUM_BITS-1:0]    window_sum,
	output logic signed [SAMPLE_BITS-1:0] window_mean
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: accept, scan, divide, hand over
	swstat_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// ring memory, min/max/sum scan, divider and output register
	swstat_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.sample              (sample),
		.window_length_write (window_length_write),
		.window_length       (window_length),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.window_count        (window_count),
		.window_min          (window_min),
		.window_max          (window_max),
		.window_sum          (window_sum),
		.window_mean         (window_mean)
	);

endmodule

// ===== rtl/swstat_ctrl.sv =====
module swstat_ctrl
	import swstat_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				cmd.start    = sample_valid;
			end
			ST_SCAN: begin
				cmd.scan      = 1'b1;
				cmd.div_start = status.scan_done;
			end
			ST_DIV: begin
				cmd.div_step = !status.div_done;
			end
			ST_DONE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/swstat_dp.sv =====
module swstat_dp
	import swstat_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_cmd_t                     cmd,
	output dp_status_t                    status,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          window_length_write,
	input  logic [LENGTH_BITS-1:0]        window_length,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [COUNT_BITS-1:0]         window_count,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SUM_BITS-1:0]    window_sum,
	output logic signed [SAMPLE_BITS-1:0] window_mean
);

	localparam int ST_BITS = PTR_BITS + 2;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	logic [LENGTH_BITS-1:0] len_q;
	logic [PTR_BITS-1:0]    wp_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [PTR_BITS-1:0]    rd_addr_q;
	logic [COUNT_BITS-1:0]  left_q;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [DIVC_BITS-1:0]   div_cnt_q;
	logic                   out_valid_q;

	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic [SUM_BITS-1:0]           quo_q;
	logic [COUNT_BITS-1:0]         rem_q;
	logic                          neg_q;

	logic [COUNT_BITS-1:0] limit;
	logic [COUNT_BITS:0]   cnt_inc;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [PTR_BITS-1:0]   wp_next;
	logic [PTR_BITS-1:0]   rd_next;
	logic [ST_BITS-1:0]    start_raw;
	logic [PTR_BITS-1:0]   start_addr;
	logic [SUM_BITS-1:0]   sum_mag;
	logic [COUNT_BITS:0]   rem_shift;
	logic                  quo_bit;
	logic [COUNT_BITS:0]   rem_diff;
	logic [SUM_BITS-1:0]   mean_full;
	logic signed [SAMPLE_BITS-1:0] rd_val;
	logic signed [SUM_BITS-1:0]    rd_ext;

	// length of zero keeps the newest sample; above capacity clamps
	always_comb begin
		if (len_q == '0) begin
			limit = COUNT_BITS'(1);
		end else if (int'(len_q) > DEPTH) begin
			limit = COUNT_BITS'(DEPTH);
		end else begin
			limit = COUNT_BITS'(len_q);
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + (COUNT_BITS + 1)'(1);
	assign cnt_new = (cnt_inc > {1'b0, limit}) ? limit : cnt_inc[COUNT_BITS-1:0];

	assign wp_next = (wp_q == PTR_BITS'(DEPTH - 1)) ? '0 : wp_q + PTR_BITS'(1);
	assign rd_next = (rd_addr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_addr_q + PTR_BITS'(1);

	// oldest held entry: wp + 1 - count, modulo depth
	assign start_raw = ST_BITS'(wp_q) + ST_BITS'(DEPTH + 1) - ST_BITS'(cnt_new);
	assign start_addr = (start_raw >= ST_BITS'(DEPTH)) ?
		PTR_BITS'(start_raw - ST_BITS'(DEPTH)) : PTR_BITS'(start_raw);

	assign rd_val = $signed(rd_data_s1);
	assign rd_ext = {{(SUM_BITS - SAMPLE_BITS){rd_data_s1[SAMPLE_BITS-1]}}, rd_data_s1};

	assign sum_mag = sum_q[SUM_BITS-1] ? (~sum_q + SUM_BITS'(1)) : sum_q;

	// restoring divide, one quotient bit per step
	assign rem_shift = {rem_q, quo_q[SUM_BITS-1]};
	assign quo_bit   = (rem_shift >= {1'b0, cnt_q});
	assign rem_diff  = rem_shift - {1'b0, cnt_q};

	assign mean_full = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;

	assign status.scan_done = (left_q == '0) && !rd_vld_s1;
	assign status.div_done  = (div_cnt_q == '0);
	assign status.out_free  = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mem[wp_q] <= sample;
		end
		rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LENGTH_BITS'(LENGTH_RESET);
			wp_q        <= '0;
			cnt_q       <= '0;
			rd_addr_q   <= '0;
			left_q      <= '0;
			rd_vld_s1   <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (window_length_write) begin
				len_q <= window_length;
			end
			if (cmd.start) begin
				wp_q      <= wp_next;
				cnt_q     <= cnt_new;
				rd_addr_q <= start_addr;
				left_q    <= cnt_new;
			end else if (cmd.scan && left_q != '0) begin
				rd_addr_q <= rd_next;
				left_q    <= left_q - COUNT_BITS'(1);
			end
			rd_vld_s1 <= cmd.scan && (left_q != '0);
			if (cmd.div_start) begin
				div_cnt_q <= DIVC_BITS'(SUM_BITS);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DIVC_BITS'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q  <= sample;
			hi_q  <= sample;
			sum_q <= '0;
		end else if (cmd.scan && rd_vld_s1) begin
			if (rd_val < lo_q) lo_q <= rd_val;
			if (rd_val > hi_q) hi_q <= rd_val;
			sum_q <= sum_q + rd_ext;
		end
		if (cmd.div_start) begin
			quo_q <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_BITS-1];
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_BITS-2:0], quo_bit};
			rem_q <= quo_bit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
		end
		if (cmd.load_out) begin
			window_count <= cnt_q;
			window_min   <= lo_q;
			window_max   <= hi_q;
			window_sum   <= sum_q;
			window_mean  <= $signed(mean_full[SAMPLE_BITS-1:0]);
		end
	end

endmodule
